// ===== src/binary_rate_multiplier_step_sequencer_defines.svh =====
// Assertion macros used by the checker file.
`ifndef BINARY_RATE_MULTIPLIER_STEP_SEQUENCER_DEFINES_SVH
`define BINARY_RATE_MULTIPLIER_STEP_SEQUENCER_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define BRMSS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define BRMSS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/brmss_pkg.sv =====
package brmss_pkg;

    localparam int AXES_MAX    = 8;
    localparam int PLANES_MAX  = 8;
    localparam int LANE_W      = 8;
    localparam int DIST_W      = 64;
    localparam int MASK_W      = 8;
    localparam int START_W     = 8;
    localparam int DEPTH_W     = 4;
    localparam int QUEUE_DEPTH = 2;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_TICK = 1'b1;

    // start index of a run, by depth - 1
    localparam logic [START_W-1:0] START_TABLE [PLANES_MAX] =
        '{8'd0, 8'd2, 8'd6, 8'd14, 8'd30, 8'd62, 8'd126, 8'd254};

    typedef logic [AXES_MAX-1:0] plane_t;

    // classified item passed from front to back; planes are stored MSB plane first
    typedef struct packed {
        logic                          is_tick;
        plane_t [PLANES_MAX-1:0]       planes;
        logic [START_W-1:0]            start;
    } brmss_item_t;

endpackage

// ===== src/brmss_in_if.sv =====
interface brmss_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [63:0] distances;

    modport source (output valid, output func, output distances, input ready);
    modport sink   (input valid, input func, input distances, output ready);
endinterface

// ===== src/brmss_out_if.sv =====
interface brmss_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] step_mask;
    logic       run_last;
    logic       stepping;

    modport source (output valid, output step_mask, output run_last, output stepping,
                    input ready);
    modport sink   (input valid, input step_mask, input run_last, input stepping,
                    output ready);
endinterface

// ===== src/brmss_front.sv =====
module brmss_front #(
    parameter int AXES   = 8,
    parameter int PLANES = 8
) (
    brmss_in_if.sink              in_ch,
    input  logic                  full,
    output logic                  push,
    output brmss_pkg::brmss_item_t push_item
);
    import brmss_pkg::*;

    plane_t [PLANES_MAX-1:0] planes;
    logic [DEPTH_W-1:0]      depth;

    // bit-plane slicing and depth search
    always_comb
    begin
        planes = '0;
        depth  = DEPTH_W'(1);
        for (int a = 0; a < AXES; a++)
        begin
            for (int b = 0; b < PLANES; b++)
            begin
                planes[b][a] = in_ch.distances[a*LANE_W + b];
            end
        end
        for (int b = 0; b < PLANES; b++)
        begin
            if (|planes[b])
            begin
                depth = DEPTH_W'(b + 1);
            end
        end
    end

    // entry i holds plane depth-1-i, zero beyond depth
    always_comb
    begin
        push_item.is_tick = (in_ch.func == FUNC_TICK);
        push_item.start   = START_TABLE[3'(depth - DEPTH_W'(1))];
        for (int i = 0; i < PLANES_MAX; i++)
        begin
            if (DEPTH_W'(i) < depth)
            begin
                push_item.planes[i] = planes[3'(depth - DEPTH_W'(1) - DEPTH_W'(i))];
            end
            else
            begin
                push_item.planes[i] = '0;
            end
        end
    end

    assign in_ch.ready = !full;
    assign push        = in_ch.valid && !full;

endmodule

// ===== src/brmss_queue.sv =====
module brmss_queue #(
    parameter int DEPTH = 2
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  brmss_pkg::brmss_item_t push_item,
    output logic                   full,
    input  logic                   pop,
    output logic                   head_valid,
    output brmss_pkg::brmss_item_t head_item
);
    import brmss_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    brmss_item_t        entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        if (p == PTR_W'(DEPTH - 1))
        begin
            return '0;
        end
        return p + PTR_W'(1);
    endfunction

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_item;
        end
    end

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entries_reg[rd_ptr_reg];

endmodule

// ===== src/brmss_back.sv =====
module brmss_back #(
    parameter int AXES   = 8,
    parameter int PLANES = 8
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   head_valid,
    input  brmss_pkg::brmss_item_t head_item,
    output logic                   pop,
    brmss_out_if.source            out_ch
);
    import brmss_pkg::*;

    localparam int IDX_W = (PLANES > 1) ? $clog2(PLANES) : 1;

    typedef logic [PLANES-1:0][AXES-1:0] bank_t;

    bank_t               bank_reg [2];
    logic [PLANES-1:0]   run_index_reg, run_index_next;
    logic [PLANES-1:0]   standby_start_reg, standby_start_next;
    logic                standby_valid_reg, standby_valid_next;
    logic                run_active_reg, run_active_next;
    logic                active_bank_reg, active_bank_next;
    logic                out_valid_reg, out_valid_next;
    logic [MASK_W-1:0]   out_mask_reg;
    logic                out_last_reg;
    logic                out_stepping_reg;

    logic                slot_free;
    logic                do_tick;
    logic                do_load;
    logic                promote_now;
    logic                active_now;
    logic                standby_after;
    logic                bank_sel;
    bank_t               cur_bank;
    logic [PLANES-1:0]   idx0, idx1;
    logic [AXES-1:0]     mask0, mask;
    logic                last;

    // number of trailing ones; the run index never reaches the top bit's position
    function automatic logic [IDX_W-1:0] plane_sel(input logic [PLANES-1:0] v);
        logic [IDX_W-1:0] cnt;
        logic             ones;
        cnt  = '0;
        ones = 1'b1;
        for (int i = 0; i < PLANES - 1; i++)
        begin
            ones = ones & v[i];
            cnt  = cnt + IDX_W'(ones);
        end
        return cnt;
    endfunction

    assign slot_free = !out_valid_reg || out_ch.ready;
    assign pop       = head_valid && (!head_item.is_tick || slot_free);
    assign do_tick   = pop && head_item.is_tick;
    assign do_load   = pop && !head_item.is_tick;

    always_comb
    begin
        promote_now   = !run_active_reg && standby_valid_reg;
        active_now    = run_active_reg || standby_valid_reg;
        standby_after = standby_valid_reg && !promote_now;
        bank_sel      = promote_now ? !active_bank_reg : active_bank_reg;
        idx0          = promote_now ? standby_start_reg : run_index_reg;
        cur_bank      = bank_reg[bank_sel];
        mask0         = cur_bank[plane_sel(idx0)];
        // empty plane: borrow the next index once, but never below zero
        if (mask0 == '0 && idx0 != '0)
        begin
            idx1 = idx0 - PLANES'(1);
            mask = cur_bank[plane_sel(idx1)];
        end
        else
        begin
            idx1 = idx0;
            mask = mask0;
        end
        last = (idx1 == '0);

        run_index_next     = run_index_reg;
        standby_start_next = standby_start_reg;
        standby_valid_next = standby_valid_reg;
        run_active_next    = run_active_reg;
        active_bank_next   = active_bank_reg;

        if (do_load)
        begin
            standby_start_next = head_item.start[PLANES-1:0];
            standby_valid_next = 1'b1;
        end
        else if (do_tick && active_now)
        begin
            if (last)
            begin
                if (standby_after)
                begin
                    active_bank_next   = !bank_sel;
                    run_index_next     = standby_start_reg;
                    run_active_next    = 1'b1;
                    standby_valid_next = 1'b0;
                end
                else
                begin
                    active_bank_next   = bank_sel;
                    run_active_next    = 1'b0;
                    standby_valid_next = 1'b0;
                end
            end
            else
            begin
                active_bank_next   = bank_sel;
                run_index_next     = idx1 - PLANES'(1);
                run_active_next    = 1'b1;
                standby_valid_next = standby_after;
            end
        end

        out_valid_next = out_valid_reg;
        if (do_tick)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_index_reg     <= '0;
            standby_start_reg <= '0;
            standby_valid_reg <= 1'b0;
            run_active_reg    <= 1'b0;
            active_bank_reg   <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            run_index_reg     <= run_index_next;
            standby_start_reg <= standby_start_next;
            standby_valid_reg <= standby_valid_next;
            run_active_reg    <= run_active_next;
            active_bank_reg   <= active_bank_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // plane banks and result payload
    always_ff @(posedge clk)
    begin
        if (do_load)
        begin
            for (int b = 0; b < PLANES; b++)
            begin
                bank_reg[!active_bank_reg][b] <= head_item.planes[b][AXES-1:0];
            end
        end
        if (do_tick)
        begin
            out_mask_reg     <= active_now ? MASK_W'(mask) : '0;
            out_last_reg     <= active_now && last;
            out_stepping_reg <= active_now;
        end
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.step_mask = out_mask_reg;
    assign out_ch.run_last  = out_last_reg;
    assign out_ch.stepping  = out_stepping_reg;

endmodule

// ===== src/binary_rate_multiplier_step_sequencer.sv =====
// A tick result is held in a queue entry, then in the result register; it waits in the queue while that is stalled.
// Loads give no result and are absorbed one per cycle while no tick waits at the queue head.
// Throughput: one item per cycle while the result is taken; a 2-entry queue between classifier and sequencer
// lets each side stall alone, the result register lets input flow while output waits.
// Reset (rst_n, async low): queue empty, no run, no standby run, bank 0 active.
module binary_rate_multiplier_step_sequencer #(
    parameter int AXES   = 8,
    parameter int PLANES = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    brmss_in_if.sink    in_ch,
    brmss_out_if.source out_ch
);
    import brmss_pkg::*;

    logic        push;
    logic        full;
    logic        pop;
    logic        head_valid;
    brmss_item_t push_item;
    brmss_item_t head_item;

    brmss_front #(
        .AXES   (AXES),
        .PLANES (PLANES)
    ) u_front (
        .in_ch     (in_ch),
        .full      (full),
        .push      (push),
        .push_item (push_item)
    );

    brmss_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    brmss_back #(
        .AXES   (AXES),
        .PLANES (PLANES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_item  (head_item),
        .pop        (pop),
        .out_ch     (out_ch)
    );

endmodule

// ===== src/brmss_checker.sv =====
`include "binary_rate_multiplier_step_sequencer_defines.svh"

module brmss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] step_mask,
    input logic       run_last,
    input logic       stepping
);

    // a stalled result stays offered, unchanged
    `BRMSS_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped under stall")
    `BRMSS_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(step_mask) && $stable(run_last) && $stable(stepping), "result changed under stall")

    // an idle tick carries no steps and ends no run
    `BRMSS_ASSERT_NOW(a_idle_quiet, out_valid && !stepping, step_mask == 8'd0 && !run_last, "idle tick with steps")
    `BRMSS_ASSERT_NOW(a_last_in_run, out_valid && run_last, stepping, "run end outside a run")

endmodule

bind binary_rate_multiplier_step_sequencer brmss_checker u_brmss_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .step_mask (out_ch.step_mask),
    .run_last  (out_ch.run_last),
    .stepping  (out_ch.stepping)
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
    import brmss_pkg::*;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 11;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 120;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASE_ITEMS  = 350;
    localparam int BURST_ITEMS  = 40;
    localparam int SHOW_MAX     = 10;
    localparam int DIR_ROWS     = 22;

    typedef struct packed {
        logic [MASK_W-1:0] step_mask;
        logic              run_last;
        logic              stepping;
    } step_t;

    typedef struct {
        logic              func;
        logic [DIST_W-1:0] dists;
        bit                typed;
        step_t             want;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n;

    brmss_in_if  in_ch();
    brmss_out_if out_ch();

    binary_rate_multiplier_step_sequencer u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // sequencer state as the predictor sees it
    logic [MASK_W-1:0] plane_mem [16];
    logic [7:0]        run_idx;
    logic [7:0]        pend_start;
    bit                pend_valid;
    bit                running;
    bit                bank;

    step_t    step_q [$];
    dir_row_t dir_rows [DIR_ROWS];

    int  send_idle_pct;
    int  ready_stall_pct;
    bit  holding;
    int  mism = 0;
    int  quiet = 0;
    event hold_ev;

    function automatic int unsigned ones_below(logic [7:0] v);
        int unsigned n;
        n = 0;
        while (n < 8 && v[n])
            n++;
        return n;
    endfunction

    function automatic void take_standby();
        bank       = ~bank;
        run_idx    = pend_start;
        running    = 1'b1;
        pend_valid = 1'b0;
    endfunction

    // bit-plane split into the standby bank, MSB plane first
    function automatic void slice_planes(logic [DIST_W-1:0] dists);
        logic [MASK_W-1:0] pl [8];
        int depth;
        int wb;
        depth = 1;
        wb    = bank ? 0 : 8;
        for (int b = 0; b < 8; b++)
            pl[b] = '0;
        for (int a = 0; a < 8; a++)
        begin
            for (int b = 0; b < 8; b++)
            begin
                if (dists[8*a + b])
                begin
                    pl[b][a] = 1'b1;
                    if (b + 1 > depth)
                        depth = b + 1;
                end
            end
        end
        for (int i = 0; i < 8; i++)
            plane_mem[wb + i] = (i < depth) ? pl[depth - 1 - i] : '0;
        pend_start = 8'((1 << depth) - 2);
        pend_valid = 1'b1;
    endfunction

    function automatic step_t advance_tick();
        step_t             s;
        int                base;
        logic [7:0]        i;
        logic [MASK_W-1:0] m;
        s = '0;
        if (!running && pend_valid)
            take_standby();
        if (!running)
            return s;
        base = bank ? 8 : 0;
        i    = run_idx;
        m    = plane_mem[base + ones_below(i)];
        // empty plane: fall through to the next index, but never below zero
        if (m == '0 && i > 0)
        begin
            i = i - 8'd1;
            m = plane_mem[base + ones_below(i)];
        end
        s.step_mask = m;
        s.stepping  = 1'b1;
        s.run_last  = (i == 0);
        if (i == 0)
        begin
            running = 1'b0;
            if (pend_valid)
                take_standby();
        end
        else
        begin
            run_idx = i - 8'd1;
        end
        return s;
    endfunction

    function automatic logic [DIST_W-1:0] rand_distances();
        logic [DIST_W-1:0] d;
        int r;
        int w;
        r = $urandom_range(0, 99);
        if (r < 4)
            return '0;
        if (r < 7)
            return {$urandom, $urandom};
        // mostly shallow runs so many of them complete
        w = $urandom_range(1, 4);
        d = '0;
        for (int a = 0; a < 8; a++)
            if ($urandom_range(0, 9) >= 3)
                d[8*a +: 8] = 8'($urandom) & 8'((1 << w) - 1);
        return d;
    endfunction

    // enters and leaves at a falling edge; valid stays up for back-to-back transfers
    task automatic push_item(logic f, logic [DIST_W-1:0] d, bit typed, step_t want);
        step_t s;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.func      <= f;
        in_ch.distances <= d;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        if (f == FUNC_LOAD)
        begin
            slice_planes(d);
        end
        else
        begin
            s = advance_tick();
            step_q.push_back(typed ? want : s);
        end
        @(negedge clk);
    endtask

    task automatic push_random();
        if ($urandom_range(0, 99) < 22)
            push_item(FUNC_LOAD, rand_distances(), 1'b0, '0);
        else
            push_item(FUNC_TICK, {$urandom, $urandom}, 1'b0, '0);
    endtask

    task automatic drain();
        in_ch.valid <= 1'b0;
        while (step_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // receiver side
    initial
    begin
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            out_ch.ready <= !holding && ($urandom_range(0, 99) >= ready_stall_pct);
        end
    end

    // long receiver hold-off, counted here
    initial
    begin
        holding = 1'b0;
        forever
        begin
            @(hold_ev);
            holding = 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            holding = 1'b0;
        end
    end

    always @(posedge clk)
    begin : check_steps
        step_t want;
        step_t got;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.step_mask, out_ch.run_last, out_ch.stepping};
            if (step_q.size() == 0)
            begin
                mism++;
                if (mism <= SHOW_MAX)
                    $display("unexpected step transfer: mask %02h last %0b stepping %0b",
                             got.step_mask, got.run_last, got.stepping);
            end
            else
            begin
                want = step_q.pop_front();
                if (got.step_mask !== want.step_mask || got.run_last !== want.run_last ||
                    got.stepping !== want.stepping)
                begin
                    mism++;
                    if (mism <= SHOW_MAX)
                        $display("step mismatch: want %02h/%0b/%0b got %02h/%0b/%0b",
                                 want.step_mask, want.run_last, want.stepping,
                                 got.step_mask, got.run_last, got.stepping);
                end
            end
        end
    end

    // no transfer on either side for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        begin
            quiet <= 0;
        end
        else if (quiet >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
        else
        begin
            quiet <= quiet + 1;
        end
    end

    initial
    begin
        rst_n           = 1'b0;
        in_ch.valid     = 1'b0;
        in_ch.func      = FUNC_LOAD;
        in_ch.distances = '0;
        for (int i = 0; i < 16; i++)
            plane_mem[i] = '0;
        run_idx         = '0;
        pend_start      = '0;
        pend_valid      = 1'b0;
        running         = 1'b0;
        bank            = 1'b0;
        send_idle_pct   = 0;
        ready_stall_pct = 0;

        dir_rows = '{
            '{FUNC_TICK, 64'h0,                  1'b1, '{8'h00, 1'b0, 1'b0}}, // idle
            '{FUNC_LOAD, 64'h0,                  1'b0, '0},
            '{FUNC_TICK, 64'h0,                  1'b1, '{8'h00, 1'b1, 1'b1}}, // zero run
            '{FUNC_TICK, 64'h0,                  1'b1, '{8'h00, 1'b0, 1'b0}},
            '{FUNC_LOAD, 64'h1,                  1'b0, '0},
            '{FUNC_LOAD, 64'h0203,               1'b0, '0},                   // overwrite
            '{FUNC_TICK, 64'h0,                  1'b1, '{8'h03, 1'b0, 1'b1}},
            '{FUNC_LOAD, 64'h4,                  1'b0, '0},                   // sparse planes
            '{FUNC_TICK, 64'h0,                  1'b0, '0},
            '{FUNC_TICK, 64'h0,                  1'b0, '0},                   // last, swap
            '{FUNC_TICK, 64'h0,                  1'b0, '0},
            '{FUNC_TICK, 64'h0,                  1'b0, '0},                   // skips
            '{FUNC_TICK, 64'h0,                  1'b0, '0},
            '{FUNC_TICK, 64'h0,                  1'b0, '0},
            '{FUNC_TICK, 64'h0,                  1'b1, '{8'h00, 1'b0, 1'b0}},
            '{FUNC_LOAD, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, '0},
            '{FUNC_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{8'hFF, 1'b0, 1'b1}},
            '{FUNC_LOAD, 64'h8000_0000_0000_0000, 1'b0, '0},
            '{FUNC_TICK, 64'h0,                  1'b0, '0},
            '{FUNC_LOAD, 64'h0102_0408_1020_4080, 1'b0, '0},
            '{FUNC_TICK, 64'h0,                  1'b0, '0},
            '{FUNC_LOAD, 64'h0,                  1'b0, '0}
        };

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[k])
            push_item(dir_rows[k].func, dir_rows[k].dists, dir_rows[k].typed, dir_rows[k].want);

        // receiver holds off while items keep coming, so the input backs up
        -> hold_ev;
        repeat (BURST_ITEMS) push_random();
        drain();

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin send_idle_pct = 0;  ready_stall_pct = 0;  end
                1: begin send_idle_pct = 88; ready_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  ready_stall_pct = 88; end
                default: begin send_idle_pct = 9; ready_stall_pct = 9; end
            endcase
            repeat (PHASE_ITEMS) push_random();
            drain();
        end

        if (mism == 0 && step_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
